[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the name/address table.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define MNAT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define MNAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mnat_pkg.sv]
// Types and constants for the masked name/address table.
// No dependencies; used by the top level.
package mnat_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS     = 32;
	localparam int MATCH_CW        = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_UNKNOWN     = 3'd1,
		ST_NOT_ALLOWED = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] addr;
		logic        flag;
	} entry_t;

endpackage

[sv/mnat_if.sv]
// Request and response channel interfaces of the name/address table.
// Plain valid/ready handshake; no package dependency.
interface mnat_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] name;
	logic [15:0] address;
	logic [1:0]  flags;
	logic [31:0] mask;

	modport source (output valid, cmd, name, address, flags, mask, input ready);
	modport sink   (input valid, cmd, name, address, flags, mask, output ready);
endinterface

interface mnat_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] entry_name_out;
	logic [15:0] entry_address_out;
	logic        entry_flag_out;
	logic        last;

	modport source (output valid, status, entry_name_out, entry_address_out,
		entry_flag_out, last, input ready);
	modport sink   (input valid, status, entry_name_out, entry_address_out,
		entry_flag_out, last, output ready);
endinterface

[sv/masked_name_address_table.sv]
// Lookup, add and remove scan the used entries in order and stop at the first hit (in slot k);
// a remove that deletes then shifts every entry behind it down one slot.
// A query result leaves when the next match is found; the last leaves from the response state.
// One request at a time; the next is taken in the cycle after the response register
// loads, and the response waits while the output is stalled.
// Reset: entry count and own device clear at once; entry memory is not cleared.
module masked_name_address_table #(
	parameter int TABLE_DEPTH = mnat_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	mnat_req_if.sink    req,
	mnat_rsp_if.source  rsp
);
`include "assert_macros.svh"

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = mnat_pkg::MATCH_CW;

	mnat_pkg::entry_t mem [TABLE_DEPTH];

	mnat_pkg::state_t state_q, state_d;
	mnat_pkg::cmd_t   cmd_q;
	logic [31:0] name_q, mask_q;
	logic [15:0] addr_q;
	logic [1:0]  flags_q;
	logic [7:0]  own_q;
	logic [CW-1:0] used_q, used_d;

	logic [CW-1:0] rd_idx_q, rd_idx_d;
	logic          s1_vld_q, s1_vld_d;
	logic [IW-1:0] s1_idx_q, s1_idx_d;
	mnat_pkg::entry_t rdata_s1;

	logic          found_q, found_d;
	logic [IW-1:0] slot_q, slot_d;
	logic [15:0]   hit_addr_q, hit_addr_d;
	logic          hit_flag_q, hit_flag_d;
	logic [MW-1:0] mcnt_q, mcnt_d;

	logic             res_vld_q, res_vld_d;
	mnat_pkg::status_t res_st_q, res_st_d;
	logic [31:0]      res_name_q, res_name_d;
	logic [15:0]      res_addr_q, res_addr_d;
	logic             res_flag_q, res_flag_d;

	logic             out_vld_q;
	mnat_pkg::status_t out_st_q;
	logic [31:0]      out_name_q;
	logic [15:0]      out_addr_q;
	logic             out_flag_q, out_last_q;
	logic             out_load, out_last_d;

	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	mnat_pkg::entry_t wr_data;

	logic accepted, out_free, issue_ok, s1_hit, hit;

	assign req.ready = (state_q == mnat_pkg::S_IDLE);
	assign accepted  = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign issue_ok  = rd_idx_q < used_q;
	assign s1_hit    = (cmd_q == mnat_pkg::CMD_QUERY) ?
		((rdata_s1.key & mask_q) == (name_q & mask_q)) : (rdata_s1.key == name_q);
	assign hit       = s1_vld_q && s1_hit;

	assign rsp.valid             = out_vld_q;
	assign rsp.status            = out_st_q;
	assign rsp.entry_name_out    = out_name_q;
	assign rsp.entry_address_out = out_addr_q;
	assign rsp.entry_flag_out    = out_flag_q;
	assign rsp.last              = out_last_q;

	always_comb begin
		state_d    = state_q;
		used_d     = used_q;
		rd_idx_d   = rd_idx_q;
		s1_vld_d   = s1_vld_q;
		s1_idx_d   = s1_idx_q;
		found_d    = found_q;
		slot_d     = slot_q;
		hit_addr_d = hit_addr_q;
		hit_flag_d = hit_flag_q;
		mcnt_d     = mcnt_q;
		res_vld_d  = res_vld_q;
		res_st_d   = res_st_q;
		res_name_d = res_name_q;
		res_addr_d = res_addr_q;
		res_flag_d = res_flag_q;
		out_load   = 1'b0;
		out_last_d = 1'b1;
		rd_en      = 1'b0;
		rd_addr    = rd_idx_q[IW-1:0];
		wr_en      = 1'b0;
		wr_addr    = slot_q;
		wr_data    = '{key: name_q, addr: addr_q, flag: flags_q[0]};

		unique case (state_q)
			mnat_pkg::S_IDLE: begin
				if (accepted) begin
					rd_idx_d  = '0;
					s1_vld_d  = 1'b0;
					found_d   = 1'b0;
					mcnt_d    = '0;
					res_vld_d = 1'b0;
					state_d   = mnat_pkg::S_SCAN;
				end
			end
			mnat_pkg::S_SCAN: begin
				if (!(cmd_q == mnat_pkg::CMD_QUERY && hit && res_vld_q && !out_free)) begin
					rd_en    = issue_ok;
					s1_vld_d = issue_ok;
					s1_idx_d = rd_idx_q[IW-1:0];
					if (issue_ok) begin
						rd_idx_d = rd_idx_q + CW'(1);
					end
					if (cmd_q == mnat_pkg::CMD_QUERY) begin
						if (hit) begin
							out_load   = res_vld_q;
							out_last_d = 1'b0;
							res_vld_d  = 1'b1;
							res_st_d   = mnat_pkg::ST_OK;
							res_name_d = rdata_s1.key;
							res_addr_d = rdata_s1.addr;
							res_flag_d = rdata_s1.flag;
							mcnt_d     = mcnt_q + MW'(1);
							if (mcnt_q == MW'(mnat_pkg::MAX_RESULTS - 1)) begin
								s1_vld_d = 1'b0;
								state_d  = mnat_pkg::S_FIN;
							end
						end
					end else if (hit) begin
						found_d    = 1'b1;
						slot_d     = s1_idx_q;
						hit_addr_d = rdata_s1.addr;
						hit_flag_d = rdata_s1.flag;
						s1_vld_d   = 1'b0;
						state_d    = mnat_pkg::S_FIN;
					end
					if (!s1_vld_q && !issue_ok) begin
						state_d = mnat_pkg::S_FIN;
					end
				end
			end
			mnat_pkg::S_FIN: begin
				res_name_d = '0;
				res_addr_d = '0;
				res_flag_d = 1'b0;
				state_d    = mnat_pkg::S_RESP;
				unique case (cmd_q)
					mnat_pkg::CMD_ADD: begin
						if (flags_q[1]) begin
							res_st_d = mnat_pkg::ST_UNKNOWN;
						end else if (found_q) begin
							if (hit_flag_q) begin
								res_st_d = mnat_pkg::ST_NOT_ALLOWED;
							end else begin
								wr_en    = 1'b1;
								res_st_d = mnat_pkg::ST_OK;
							end
						end else if (addr_q == {own_q, 8'h00}) begin
							res_st_d = mnat_pkg::ST_NOT_ALLOWED;
						end else if (used_q == CW'(TABLE_DEPTH)) begin
							res_st_d = mnat_pkg::ST_FULL;
						end else begin
							wr_en    = 1'b1;
							wr_addr  = used_q[IW-1:0];
							used_d   = used_q + CW'(1);
							res_st_d = mnat_pkg::ST_OK;
						end
					end
					mnat_pkg::CMD_REMOVE: begin
						if (!found_q) begin
							res_st_d = mnat_pkg::ST_UNKNOWN;
						end else if (hit_flag_q) begin
							res_st_d = mnat_pkg::ST_NOT_ALLOWED;
						end else begin
							res_st_d = mnat_pkg::ST_OK;
							rd_idx_d = CW'(slot_q) + CW'(1);
							s1_vld_d = 1'b0;
							state_d  = mnat_pkg::S_SHIFT;
						end
					end
					mnat_pkg::CMD_LOOKUP: begin
						if (found_q) begin
							res_st_d   = mnat_pkg::ST_OK;
							res_addr_d = hit_addr_q;
							res_flag_d = hit_flag_q;
						end else begin
							res_st_d = mnat_pkg::ST_NOT_FOUND;
						end
					end
					mnat_pkg::CMD_QUERY: begin
						if (res_vld_q) begin
							res_name_d = res_name_q;
							res_addr_d = res_addr_q;
							res_flag_d = res_flag_q;
						end else begin
							res_st_d = mnat_pkg::ST_NOT_FOUND;
						end
					end
				endcase
			end
			mnat_pkg::S_SHIFT: begin
				rd_en    = issue_ok;
				s1_vld_d = issue_ok;
				s1_idx_d = rd_idx_q[IW-1:0];
				if (issue_ok) begin
					rd_idx_d = rd_idx_q + CW'(1);
				end
				if (s1_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = s1_idx_q - IW'(1);
					wr_data = rdata_s1;
				end
				if (!s1_vld_q && !issue_ok) begin
					used_d  = used_q - CW'(1);
					state_d = mnat_pkg::S_RESP;
				end
			end
			mnat_pkg::S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = mnat_pkg::S_IDLE;
				end
			end
			default: state_d = mnat_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mnat_pkg::S_IDLE;
			used_q    <= '0;
			own_q     <= '0;
			s1_vld_q  <= 1'b0;
			found_q   <= 1'b0;
			res_vld_q <= 1'b0;
			mcnt_q    <= '0;
			rd_idx_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			s1_vld_q  <= s1_vld_d;
			found_q   <= found_d;
			res_vld_q <= res_vld_d;
			mcnt_q    <= mcnt_d;
			rd_idx_q  <= rd_idx_d;
			if (cfg_we) begin
				own_q <= cfg_wdata;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		s1_idx_q   <= s1_idx_d;
		slot_q     <= slot_d;
		hit_addr_q <= hit_addr_d;
		hit_flag_q <= hit_flag_d;
		res_st_q   <= res_st_d;
		res_name_q <= res_name_d;
		res_addr_q <= res_addr_d;
		res_flag_q <= res_flag_d;
		if (accepted) begin
			cmd_q   <= mnat_pkg::cmd_t'(req.cmd);
			name_q  <= req.name;
			addr_q  <= req.address;
			flags_q <= req.flags;
			mask_q  <= req.mask;
		end
		if (out_load) begin
			out_st_q   <= res_st_q;
			out_name_q <= res_name_q;
			out_addr_q <= res_addr_q;
			out_flag_q <= res_flag_q;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	`MNAT_ASSERT(a_used_bound, clk, arst_n, used_q <= CW'(TABLE_DEPTH), "entry count above depth")
	`MNAT_ASSERT(a_accept_scan, clk, arst_n, accepted |=> state_q == mnat_pkg::S_SCAN, "request not scanned")
	`MNAT_ASSERT(a_no_wr_in_scan, clk, arst_n, state_q == mnat_pkg::S_SCAN |-> !wr_en, "write during scan")
	`MNAT_ASSERT(a_match_cap, clk, arst_n, mcnt_q <= MW'(mnat_pkg::MAX_RESULTS), "match count overrun")

endmodule
